// ===== design/lcdns_pkg.sv =====
// shared types, codes and init tables for the character lcd nibble sequencer
`timescale 1ns / 1ps

package lcdns_pkg;

   typedef enum logic [1:0] {
      ACT_PUT_CHAR   = 2'd0,
      ACT_GOTO       = 2'd1,
      ACT_CLEAR_LINE = 2'd2,
      ACT_INIT       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DESC_BYTE  = 2'd0,
      DESC_CLEAR = 2'd1,
      DESC_INIT  = 2'd2
   } desc_kind_type;

   typedef struct packed {
      desc_kind_type kind;
      logic          rs;
      logic [7:0]    data;
   } desc_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_RUN  = 1'b1
   } back_state_type;

   localparam logic [2:0] WAIT_NONE = 3'd0;
   localparam logic [2:0] WAIT_POLL = 3'd1;
   localparam logic [2:0] WAIT_30MS = 3'd2;
   localparam logic [2:0] WAIT_40US = 3'd3;
   localparam logic [2:0] WAIT_2MS  = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_FORMFEED = 8'h0C;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
   localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;
   localparam logic [7:0] LINE_TWO_BASE = 8'h40;
   localparam logic [2:0] ROW_ONE       = 3'd1;
   localparam logic [2:0] ROW_TWO       = 3'd2;

   localparam int INIT_LEN = 10;

   function automatic logic [3:0] init_nibble(input logic [3:0] idx);
      logic [3:0] nib;
      unique case (idx)
         4'd0: nib = 4'h2;
         4'd1: nib = 4'h8;
         4'd2: nib = 4'h2;
         4'd3: nib = 4'h8;
         4'd4: nib = 4'h0;
         4'd5: nib = 4'hC;
         4'd6: nib = 4'h0;
         4'd7: nib = 4'h1;
         4'd8: nib = 4'h0;
         4'd9: nib = 4'h6;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

   function automatic logic [2:0] init_wait(input logic [3:0] idx);
      logic [2:0] w;
      unique case (idx)
         4'd0: w = WAIT_30MS;
         4'd4: w = WAIT_40US;
         4'd6: w = WAIT_40US;
         4'd8: w = WAIT_2MS;
         default: w = WAIT_NONE;
      endcase
      return w;
   endfunction

endpackage

// ===== design/lcdns_front.sv =====
// front end: accepts request beats and turns them into byte, clear or init descriptors
`timescale 1ns / 1ps

module lcdns_front
   import lcdns_pkg::*;
(
   input  logic       req_push,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_column,
   input  logic [2:0] req_row,
   output logic       req_full,
   input  logic       fifo_full,
   output logic       fifo_push,
   output desc_type   fifo_desc
);

   logic       accept;
   logic       keep;
   logic [7:0] base;
   logic [7:0] addr;

   assign accept   = req_push && !fifo_full;
   assign req_full = fifo_full;

   always_comb begin
      base = (req_row == ROW_TWO) ? LINE_TWO_BASE : 8'h00;
      addr = base + req_column + 8'hFF;
      keep = 1'b1;
      fifo_desc.kind = DESC_BYTE;
      fifo_desc.rs   = 1'b0;
      fifo_desc.data = 8'h00;
      unique case (action_type'(req_action))
         ACT_PUT_CHAR: begin
            if (req_char_code == CHAR_NEWLINE || req_char_code == CHAR_FORMFEED) begin
               fifo_desc.data = CMD_LINE_TWO;
            end else begin
               fifo_desc.rs   = 1'b1;
               fifo_desc.data = req_char_code;
            end
         end
         ACT_GOTO: begin
            fifo_desc.data = CMD_SET_ADDR | addr;
         end
         ACT_CLEAR_LINE: begin
            fifo_desc.kind = DESC_CLEAR;
            fifo_desc.data = CMD_SET_ADDR | base;
            keep = (req_row == ROW_ONE) || (req_row == ROW_TWO);
         end
         ACT_INIT: begin
            fifo_desc.kind = DESC_INIT;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      fifo_push = accept && keep;
   end

endmodule

// ===== design/lcdns_desc_fifo.sv =====
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps

module lcdns_desc_fifo
   import lcdns_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output desc_type pop_desc
);

   desc_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_desc = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("descriptor queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("descriptor queue pointers disagree with count");

endmodule

// ===== design/lcdns_back.sv =====
// back end: expands one descriptor into nibble beats through an output register
`timescale 1ns / 1ps

module lcdns_back
   import lcdns_pkg::*;
#(
   parameter int LINE_CHARS = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fifo_valid,
   input  desc_type   fifo_desc,
   output logic       fifo_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_reg_select,
   output logic [3:0] rsp_nibble,
   output logic [2:0] rsp_pre_wait,
   output logic       rsp_last
);

   localparam int ClearSteps = 2 * LINE_CHARS + 2;
   localparam int MaxSteps   = (ClearSteps > INIT_LEN) ? ClearSteps : INIT_LEN;
   localparam int StepW      = $clog2(MaxSteps);
   localparam logic [StepW-1:0] LastByte  = StepW'(1);
   localparam logic [StepW-1:0] LastClear = StepW'(ClearSteps - 1);
   localparam logic [StepW-1:0] LastInit  = StepW'(INIT_LEN - 1);

   back_state_type   state_ff, state_in;
   desc_type         desc_ff, desc_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_rs_ff, out_rs_in;
   logic [3:0]       out_nib_ff, out_nib_in;
   logic [2:0]       out_wait_ff, out_wait_in;
   logic             out_last_ff, out_last_in;
   logic             advance;
   logic             at_last;
   logic [StepW-1:0] last_step;
   logic [7:0]       cur_byte;
   logic             cur_rs;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (fifo_valid) state_in = BACK_RUN;
         end
         BACK_RUN: begin
            if (advance && at_last) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      fifo_pop = 1'b0;
      advance  = 1'b0;
      unique case (state_ff)
         BACK_IDLE: fifo_pop = fifo_valid;
         BACK_RUN:  advance  = !out_valid_ff || rsp_pop;
         default: begin
            fifo_pop = 1'b0;
            advance  = 1'b0;
         end
      endcase
   end

   // nibble datapath
   always_comb begin
      unique case (desc_ff.kind)
         DESC_BYTE:  last_step = LastByte;
         DESC_CLEAR: last_step = LastClear;
         DESC_INIT:  last_step = LastInit;
         default:    last_step = LastByte;
      endcase
      at_last = (step_ff == last_step);

      // after the address byte a clear line sends spaces
      if (desc_ff.kind == DESC_CLEAR && step_ff[StepW-1:1] != '0) begin
         cur_byte = CHAR_SPACE;
         cur_rs   = 1'b1;
      end else begin
         cur_byte = desc_ff.data;
         cur_rs   = desc_ff.rs;
      end

      if (desc_ff.kind == DESC_INIT) begin
         out_rs_in   = 1'b0;
         out_nib_in  = init_nibble(step_ff[3:0]);
         out_wait_in = init_wait(step_ff[3:0]);
      end else begin
         out_rs_in   = cur_rs;
         out_nib_in  = step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
         out_wait_in = step_ff[0] ? WAIT_NONE : WAIT_POLL;
      end
      out_last_in = at_last;

      desc_in = fifo_pop ? fifo_desc : desc_ff;
      step_in = step_ff;
      if (fifo_pop) begin
         step_in = '0;
      end else if (advance) begin
         step_in = step_ff + StepW'(1);
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      step_ff <= step_in;
      if (advance) begin
         out_rs_ff   <= out_rs_in;
         out_nib_ff  <= out_nib_in;
         out_wait_ff <= out_wait_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_pre_wait   = out_wait_ff;
   assign rsp_last       = out_last_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_RUN) |-> (step_ff <= last_step))
      else $error("nibble step ran past end of run");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      (advance && at_last) |=> (out_valid_ff && out_last_ff && state_ff == BACK_IDLE))
      else $error("final nibble not flagged at end of run");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> (state_ff == BACK_IDLE))
      else $error("descriptor taken while a run is active");

endmodule

// ===== design/char_lcd_nibble_sequencer.sv =====
// top level of the character lcd 4-bit bus nibble sequencer
`timescale 1ns / 1ps

// Each request beat becomes a run of nibble beats, one per enable pulse, high
// nibble first, each byte led by a busy poll. A put_char or goto gives 2 beats,
// init gives 10, a clear line of row 1 or 2 gives 2*LINE_CHARS+2 and a clear
// line of any other row gives none. Requests land in a two-entry descriptor
// queue; the back end loads a descriptor in its idle state and then produces
// one nibble per cycle into its output register while pop keeps up. It takes
// no new descriptor until the last nibble of a run has entered that register.
// No clearing pass.

module char_lcd_nibble_sequencer
   import lcdns_pkg::*;
#(
   parameter int LINE_CHARS = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_column,
   input  logic [2:0] req_row,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_reg_select,
   output logic [3:0] rsp_nibble,
   output logic [2:0] rsp_pre_wait,
   output logic       rsp_last
);

   logic     fifo_full;
   logic     fifo_push;
   desc_type push_desc;
   logic     fifo_pop;
   logic     fifo_valid;
   desc_type pop_desc;

   lcdns_front u_front (
      .req_push      (req_push),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_full      (req_full),
      .fifo_full     (fifo_full),
      .fifo_push     (fifo_push),
      .fifo_desc     (push_desc)
   );

   lcdns_desc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_desc (push_desc),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .valid     (fifo_valid),
      .pop_desc  (pop_desc)
   );

   lcdns_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_valid     (fifo_valid),
      .fifo_desc      (pop_desc),
      .fifo_pop       (fifo_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_pre_wait   (rsp_pre_wait),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the character lcd nibble sequencer
`timescale 1ns / 1ps

module testbench
   import lcdns_pkg::*;
;

   localparam int LINE_CHARS = 20;
   localparam int RANDOM_REQS = 236;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 60;
   localparam int MAX_PRINTED = 40;

   localparam logic [39:0] INIT_NIBS = {4'h2, 4'h8, 4'h2, 4'h8, 4'h0,
                                        4'hC, 4'h0, 4'h1, 4'h0, 4'h6};
   localparam logic [29:0] INIT_WAITS = {WAIT_30MS, WAIT_NONE, WAIT_NONE, WAIT_NONE,
                                         WAIT_40US, WAIT_NONE, WAIT_40US, WAIT_NONE,
                                         WAIT_2MS, WAIT_NONE};

   typedef struct packed {
      action_type action;
      logic [7:0] char_code;
      logic [7:0] column;
      logic [2:0] row;
      logic       drain_first;
   } lcd_req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic [2:0] pre_wait;
      logic       last;
   } nibble_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_action = 2'd0;
   logic [7:0] req_char_code = 8'd0;
   logic [7:0] req_column = 8'd0;
   logic [2:0] req_row = 3'd0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_reg_select;
   logic [3:0] rsp_nibble;
   logic [2:0] rsp_pre_wait;
   logic       rsp_last;

   lcd_req_type     pending_reqs[$];
   nibble_beat_type expected_beats[$];
   nibble_beat_type run_beats[0:63];
   int              run_len;

   lcd_req_type cur_req;
   lcd_req_type head_req;
   int          reqs_total = -1;
   int          reqs_accepted = 0;
   int          beats_seen = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          send_calm = 0;
   int          recv_gap = 0;
   int          recv_calm = 0;

   char_lcd_nibble_sequencer #(
      .LINE_CHARS(LINE_CHARS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_action(req_action),
      .req_char_code(req_char_code),
      .req_column(req_column),
      .req_row(req_row),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_reg_select(rsp_reg_select),
      .rsp_nibble(rsp_nibble),
      .rsp_pre_wait(rsp_pre_wait),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // idle cycles before the next beat, with runs of back-to-back beats
   task automatic draw_idle(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         gap = 0;
      end else if ($urandom_range(0, 2) == 0) begin
         gap = $urandom_range(0, 18);
      end else begin
         gap = $urandom_range(0, 3);
      end
   endtask

   task automatic add_beat(input logic rs, input logic [3:0] nib, input logic [2:0] pw);
      run_beats[run_len] = {rs, nib, pw, 1'b0};
      run_len++;
   endtask

   task automatic add_byte(input logic rs, input logic [7:0] data);
      add_beat(rs, data[7:4], WAIT_POLL);
      add_beat(rs, data[3:0], WAIT_NONE);
   endtask

   task automatic add_goto(input logic [7:0] col, input logic [2:0] row);
      logic [7:0] addr;
      addr = ((row == ROW_TWO) ? LINE_TWO_BASE : 8'h00) + col - 8'd1;
      add_byte(1'b0, CMD_SET_ADDR | addr);
   endtask

   // expands one request into the nibble beats it must produce
   task automatic expand_request(input lcd_req_type rq);
      nibble_beat_type b;
      run_len = 0;
      case (rq.action)
         ACT_PUT_CHAR: begin
            if (rq.char_code == CHAR_NEWLINE || rq.char_code == CHAR_FORMFEED) begin
               add_byte(1'b0, CMD_LINE_TWO);
            end else begin
               add_byte(1'b1, rq.char_code);
            end
         end
         ACT_GOTO: begin
            add_goto(rq.column, rq.row);
         end
         ACT_CLEAR_LINE: begin
            if (rq.row == ROW_ONE || rq.row == ROW_TWO) begin
               add_goto(8'd1, rq.row);
               for (int i = 0; i < LINE_CHARS; i++) begin
                  add_byte(1'b1, CHAR_SPACE);
               end
            end
         end
         default: begin
            for (int i = 0; i < INIT_LEN; i++) begin
               add_beat(1'b0, INIT_NIBS[4 * (INIT_LEN - 1 - i) +: 4],
                        INIT_WAITS[3 * (INIT_LEN - 1 - i) +: 3]);
            end
         end
      endcase
      for (int i = 0; i < run_len; i++) begin
         b = run_beats[i];
         b.last = (i == run_len - 1);
         expected_beats.push_back(b);
      end
   endtask

   task automatic add_req(input action_type act, input logic [7:0] ch,
                          input logic [7:0] col, input logic [2:0] row);
      lcd_req_type rq;
      rq.action = act;
      rq.char_code = ch;
      rq.column = col;
      rq.row = row;
      rq.drain_first = 1'b0;
      pending_reqs.push_back(rq);
   endtask

   // request side driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            expand_request(cur_req);
            reqs_accepted++;
         end
         if (!req_push || !req_full) begin
            if (pending_reqs.size() > 0) begin
               head_req = pending_reqs[0];
            end
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(head_req.drain_first && expected_beats.size() > 0)) begin
               cur_req = pending_reqs.pop_front();
               req_action <= cur_req.action;
               req_char_code <= cur_req.char_code;
               req_column <= cur_req.column;
               req_row <= cur_req.row;
               req_push <= 1'b1;
               draw_idle(send_calm, send_gap);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // nibble side monitor and checker
   always @(posedge clock) begin
      nibble_beat_type exp_beat;
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_gap = 0;
      end else if (rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with none expected", beats_seen));
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_reg_select !== exp_beat.reg_select) begin
               report_mismatch($sformatf("beat %0d reg_select expected %0d got %0d",
                                         beats_seen, exp_beat.reg_select, rsp_reg_select));
            end
            if (rsp_nibble !== exp_beat.nibble) begin
               report_mismatch($sformatf("beat %0d nibble expected %h got %h",
                                         beats_seen, exp_beat.nibble, rsp_nibble));
            end
            if (rsp_pre_wait !== exp_beat.pre_wait) begin
               report_mismatch($sformatf("beat %0d pre_wait expected %0d got %0d",
                                         beats_seen, exp_beat.pre_wait, rsp_pre_wait));
            end
            if (rsp_last !== exp_beat.last) begin
               report_mismatch($sformatf("beat %0d last expected %0d got %0d",
                                         beats_seen, exp_beat.last, rsp_last));
            end
         end
         beats_seen++;
         draw_idle(recv_calm, recv_gap);
         rsp_pop <= (recv_gap == 0);
      end else if (!rsp_pop) begin
         if (recv_gap > 1) begin
            recv_gap--;
         end else begin
            recv_gap = 0;
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      lcd_req_type rq;
      int          counted;
      int          pick;

      // directed: character extremes and line-two codes
      add_req(ACT_PUT_CHAR, 8'h00, 8'h00, 3'd0);
      add_req(ACT_PUT_CHAR, 8'hFF, 8'hFF, 3'd7);
      add_req(ACT_PUT_CHAR, CHAR_NEWLINE, 8'h01, 3'd1);
      add_req(ACT_PUT_CHAR, CHAR_FORMFEED, 8'h02, 3'd2);
      add_req(ACT_PUT_CHAR, 8'h0B, 8'h00, 3'd0);
      add_req(ACT_PUT_CHAR, 8'h0D, 8'h00, 3'd0);
      add_req(ACT_PUT_CHAR, 8'h41, 8'h00, 3'd0);
      // goto: both lines, other rows, column zero and wrap
      add_req(ACT_GOTO, 8'h00, 8'd1, 3'd1);
      add_req(ACT_GOTO, 8'h00, 8'd1, 3'd2);
      add_req(ACT_GOTO, 8'h00, 8'd0, 3'd2);
      add_req(ACT_GOTO, 8'h00, 8'd0, 3'd0);
      add_req(ACT_GOTO, 8'hFF, 8'd255, 3'd7);
      add_req(ACT_GOTO, 8'h00, 8'd255, 3'd2);
      add_req(ACT_GOTO, 8'h00, 8'd20, 3'd3);
      add_req(ACT_GOTO, 8'h00, 8'd128, 3'd1);
      // clear line: valid rows and ignored rows
      add_req(ACT_CLEAR_LINE, 8'h00, 8'h00, 3'd1);
      add_req(ACT_CLEAR_LINE, 8'hFF, 8'hFF, 3'd2);
      add_req(ACT_CLEAR_LINE, 8'h00, 8'h00, 3'd0);
      add_req(ACT_CLEAR_LINE, 8'h00, 8'h00, 3'd3);
      add_req(ACT_CLEAR_LINE, 8'h00, 8'h00, 3'd7);
      add_req(ACT_INIT, 8'h00, 8'h00, 3'd0);
      add_req(ACT_INIT, 8'hFF, 8'hFF, 3'd7);
      add_req(ACT_PUT_CHAR, 8'h7E, 8'h00, 3'd0);

      counted = 0;
      while (counted < RANDOM_REQS) begin
         rq.char_code = 8'($urandom_range(0, 255));
         rq.column = 8'($urandom_range(0, 255));
         rq.row = 3'($urandom_range(0, 7));
         rq.drain_first = (counted == 0) || ($urandom_range(0, 39) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            rq.action = ACT_PUT_CHAR;
            if ($urandom_range(0, 9) == 0) begin
               rq.char_code = $urandom_range(0, 1) ? CHAR_NEWLINE : CHAR_FORMFEED;
            end
         end else if (pick < 70) begin
            rq.action = ACT_GOTO;
         end else if (pick < 85) begin
            rq.action = ACT_CLEAR_LINE;
            if ($urandom_range(0, 9) < 8) begin
               rq.row = $urandom_range(0, 1) ? ROW_ONE : ROW_TWO;
            end
         end else begin
            rq.action = ACT_INIT;
         end
         pending_reqs.push_back(rq);
         if (!(rq.action == ACT_CLEAR_LINE && rq.row != ROW_ONE && rq.row != ROW_TWO)) begin
            counted++;
         end
      end
      reqs_total = pending_reqs.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (reqs_accepted < reqs_total) @(posedge clock);
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/lcdns_pkg.sv
design/lcdns_front.sv
design/lcdns_desc_fifo.sv
design/lcdns_back.sv
design/char_lcd_nibble_sequencer.sv
dv/testbench.sv
